[design/sslb_pkg.sv]
// Package for the service selection load balancer: sizes, codes and the table entry type.
`default_nettype none
package sslb_pkg;

  localparam int MAX_SERVICES = 16;
  localparam int IDX_W = (MAX_SERVICES > 1) ? $clog2(MAX_SERVICES) : 1;
  localparam int CNT_W = $clog2(MAX_SERVICES + 1);

  localparam int ID_W   = 32;
  localparam int SOCK_W = 31;
  localparam int LIM_W  = 24;
  localparam int KIND_W = 3;
  localparam int STAT_W = 3;
  localparam int MODE_W = 2;

  localparam logic [LIM_W-1:0] SESS_MAX = {LIM_W{1'b1}};

  typedef enum logic [KIND_W-1:0] {
    K_PICK    = 3'd0,
    K_ATTACH  = 3'd1,
    K_DETACH  = 3'd2,
    K_SESS_ADD = 3'd3,
    K_SESS_REM = 3'd4
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_NOSVC    = 3'd1,
    ST_REFUSED  = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic [MODE_W-1:0] {
    M_ECHO    = 2'd0,
    M_SINGLE  = 2'd1,
    M_STOCK   = 2'd2,
    M_BALANCE = 2'd3
  } mode_t;

  typedef struct packed {
    logic [ID_W-1:0]   service_id;
    logic [SOCK_W-1:0] socket;
    logic [LIM_W-1:0]  limit;
    logic [LIM_W-1:0]  sessions;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

[design/sslb_in_if.sv]
// Request channel interface: valid/ready plus the request fields.
`default_nettype none
interface sslb_in_if;
  logic                         valid;
  logic                         ready;
  logic [sslb_pkg::KIND_W-1:0]  kind;
  logic [sslb_pkg::ID_W-1:0]    service_id;
  logic [sslb_pkg::SOCK_W-1:0]  socket_handle;
  logic [sslb_pkg::LIM_W-1:0]   conn_limit;

  modport source (output valid, kind, service_id, socket_handle, conn_limit, input ready);
  modport sink   (input valid, kind, service_id, socket_handle, conn_limit, output ready);
endinterface
`default_nettype wire

[design/sslb_out_if.sv]
// Result channel interface: valid/ready plus the result fields.
`default_nettype none
interface sslb_out_if;
  logic                         valid;
  logic                         ready;
  logic [sslb_pkg::STAT_W-1:0]  status;
  logic [sslb_pkg::ID_W-1:0]    chosen_service_id;

  modport source (output valid, status, chosen_service_id, input ready);
  modport sink   (input valid, status, chosen_service_id, output ready);
endinterface
`default_nettype wire

[design/sslb_ram.sv]
// Generic simple dual-port RAM, one write and one registered read per cycle.
`default_nettype none
module sslb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                          clk,
  input  wire logic                                          we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  wire logic [WIDTH-1:0]                              wdata,
  input  wire logic                                          re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output      logic [WIDTH-1:0]                              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end
endmodule
`default_nettype wire

[design/service_selection_load_balancer.sv]
// Top level of the service selection load balancer: table sequencer around one entry RAM.
//
//  channel   dir  ports                                   transfer when
//  request   in   in_ch (kind, service_id, socket, limit) in_ch.valid && in_ch.ready
//  result    out  out_ch (status, chosen_service_id)      out_ch.valid && out_ch.ready
//  config    in   cfg_we, cfg_wdata (gate_mode)           cfg_we high
//
// Echo picks and unknown kinds skip the table; every other request scans it, one entry per
// cycle through the single RAM read port, and a hit that ends the scan early stops it there.
// A detach hit then moves each later entry down, with a read (S_SH_RD) and a write (S_SH_WR) each.
// Reset (rst_n low, synchronous) empties the table and sets gate_mode to single.
// The result register frees the input side; a stalled result holds the next one back.
`default_nettype none
module service_selection_load_balancer (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  sslb_in_if.sink                          in_ch,
  sslb_out_if.source                       out_ch,
  input  wire logic                        cfg_we,
  input  wire logic [sslb_pkg::MODE_W-1:0] cfg_wdata
);
  localparam int IDX_W = sslb_pkg::IDX_W;
  localparam int CNT_W = sslb_pkg::CNT_W;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_SH_RD, S_SH_WR, S_DONE} state_t;

  state_t                        state_r, state_nxt;
  sslb_pkg::kind_t               kind_r, kind_nxt;
  sslb_pkg::mode_t               mode_r, mode_nxt;
  logic [sslb_pkg::ID_W-1:0]     id_r, id_nxt;
  logic [sslb_pkg::SOCK_W-1:0]   sock_r, sock_nxt;
  logic [sslb_pkg::LIM_W-1:0]    limit_r, limit_nxt;
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic [CNT_W-1:0]              issue_r, issue_nxt;
  logic [CNT_W-1:0]              src_r, src_nxt;
  logic                          chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]              chk_idx_r, chk_idx_nxt;
  logic                          best_found_r, best_found_nxt;
  logic [sslb_pkg::LIM_W-1:0]    best_sess_r, best_sess_nxt;
  logic [sslb_pkg::ID_W-1:0]     best_id_r, best_id_nxt;
  sslb_pkg::status_t             res_status_r, res_status_nxt;
  logic [sslb_pkg::ID_W-1:0]     res_id_r, res_id_nxt;
  logic                          out_valid_r, out_valid_nxt;
  sslb_pkg::status_t             out_status_r, out_status_nxt;
  logic [sslb_pkg::ID_W-1:0]     out_id_r, out_id_nxt;

  logic                          ram_we, ram_re;
  logic [IDX_W-1:0]              ram_waddr, ram_raddr;
  sslb_pkg::entry_t              ram_wdata, rd;
  logic [sslb_pkg::ENTRY_W-1:0]  ram_rdata;

  logic                          hit_id, hit_sock, full, out_free;
  logic [CNT_W-1:0]              src_dec;

  sslb_ram #(
    .WIDTH (sslb_pkg::ENTRY_W),
    .DEPTH (sslb_pkg::MAX_SERVICES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd       = sslb_pkg::entry_t'(ram_rdata);
  assign hit_id   = (rd.service_id == id_r);
  assign hit_sock = (rd.socket == sock_r);
  assign full     = (rd.limit != '0) && (rd.sessions >= rd.limit);
  assign out_free = !out_valid_r || out_ch.ready;
  assign src_dec  = src_r - CNT_W'(1);

  assign in_ch.ready              = (state_r == S_IDLE);
  assign out_ch.valid             = out_valid_r;
  assign out_ch.status            = out_status_r;
  assign out_ch.chosen_service_id = out_id_r;

  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    mode_nxt       = mode_r;
    id_nxt         = id_r;
    sock_nxt       = sock_r;
    limit_nxt      = limit_r;
    count_nxt      = count_r;
    issue_nxt      = issue_r;
    src_nxt        = src_r;
    chk_vld_nxt    = 1'b0;
    chk_idx_nxt    = chk_idx_r;
    best_found_nxt = best_found_r;
    best_sess_nxt  = best_sess_r;
    best_id_nxt    = best_id_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_waddr      = chk_idx_r;
    ram_raddr      = issue_r[IDX_W-1:0];
    ram_wdata      = rd;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cfg_we) begin
      mode_nxt = sslb_pkg::mode_t'(cfg_wdata);
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          kind_nxt       = sslb_pkg::kind_t'(in_ch.kind);
          id_nxt         = in_ch.service_id;
          sock_nxt       = in_ch.socket_handle;
          limit_nxt      = in_ch.conn_limit;
          issue_nxt      = '0;
          best_found_nxt = 1'b0;
          res_status_nxt = sslb_pkg::ST_OK;
          res_id_nxt     = '0;
          case (sslb_pkg::kind_t'(in_ch.kind))
            sslb_pkg::K_PICK: begin
              state_nxt = (mode_r == sslb_pkg::M_ECHO) ? S_DONE : S_SCAN;
            end
            sslb_pkg::K_ATTACH, sslb_pkg::K_DETACH,
            sslb_pkg::K_SESS_ADD, sslb_pkg::K_SESS_REM: begin
              state_nxt = S_SCAN;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        // read of entry issue_r overlaps the check of the entry read last cycle
        if (issue_r < count_r) begin
          ram_re      = 1'b1;
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = issue_r[IDX_W-1:0];
          issue_nxt   = issue_r + CNT_W'(1);
        end
        if (chk_vld_r) begin
          case (kind_r)
            sslb_pkg::K_PICK: begin
              if (mode_r == sslb_pkg::M_SINGLE) begin
                res_status_nxt = full ? sslb_pkg::ST_REFUSED : sslb_pkg::ST_OK;
                res_id_nxt     = full ? '0 : rd.service_id;
                state_nxt      = S_DONE;
              end else if (mode_r == sslb_pkg::M_STOCK) begin
                if (!full) begin
                  res_id_nxt = rd.service_id;
                  state_nxt  = S_DONE;
                end
              end else if (!full && (!best_found_r || rd.sessions < best_sess_r)) begin
                best_found_nxt = 1'b1;
                best_sess_nxt  = rd.sessions;
                best_id_nxt    = rd.service_id;
              end
            end
            sslb_pkg::K_ATTACH: begin
              if (hit_id) begin
                state_nxt = S_DONE;
              end
            end
            sslb_pkg::K_DETACH: begin
              if (hit_sock) begin
                src_nxt   = CNT_W'(chk_idx_r) + CNT_W'(1);
                state_nxt = S_SH_RD;
              end
            end
            sslb_pkg::K_SESS_ADD, sslb_pkg::K_SESS_REM: begin
              if (hit_id) begin
                ram_we    = 1'b1;
                ram_waddr = chk_idx_r;
                if (kind_r == sslb_pkg::K_SESS_ADD) begin
                  if (rd.sessions != sslb_pkg::SESS_MAX) begin
                    ram_wdata.sessions = rd.sessions + sslb_pkg::LIM_W'(1);
                  end
                end else if (rd.sessions != '0) begin
                  ram_wdata.sessions = rd.sessions - sslb_pkg::LIM_W'(1);
                end
                state_nxt = S_DONE;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end else if (issue_r == count_r) begin
          // whole table seen without an early exit
          state_nxt = S_DONE;
          case (kind_r)
            sslb_pkg::K_PICK: begin
              if (count_r == '0) begin
                res_status_nxt = sslb_pkg::ST_NOSVC;
              end else if (best_found_r) begin
                res_id_nxt = best_id_r;
              end else begin
                res_status_nxt = sslb_pkg::ST_REFUSED;
              end
            end
            sslb_pkg::K_ATTACH: begin
              if (id_r == '0) begin
                res_status_nxt = sslb_pkg::ST_REFUSED;
              end else if (count_r == CNT_W'(sslb_pkg::MAX_SERVICES)) begin
                res_status_nxt = sslb_pkg::ST_FULL;
              end else begin
                ram_we               = 1'b1;
                ram_waddr            = count_r[IDX_W-1:0];
                ram_wdata.service_id = id_r;
                ram_wdata.socket     = sock_r;
                ram_wdata.limit      = limit_r;
                ram_wdata.sessions   = '0;
                count_nxt            = count_r + CNT_W'(1);
              end
            end
            default: begin
              res_status_nxt = sslb_pkg::ST_NOTFOUND;
            end
          endcase
        end
      end

      S_SH_RD: begin
        if (src_r < count_r) begin
          ram_re    = 1'b1;
          ram_raddr = src_r[IDX_W-1:0];
          state_nxt = S_SH_WR;
        end else begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = S_DONE;
        end
      end

      S_SH_WR: begin
        ram_we    = 1'b1;
        ram_waddr = src_dec[IDX_W-1:0];
        ram_wdata = rd;
        src_nxt   = src_r + CNT_W'(1);
        state_nxt = S_SH_RD;
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_id_nxt     = res_id_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= sslb_pkg::M_SINGLE;
      count_r     <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      count_r     <= count_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    kind_r       <= kind_nxt;
    id_r         <= id_nxt;
    sock_r       <= sock_nxt;
    limit_r      <= limit_nxt;
    issue_r      <= issue_nxt;
    src_r        <= src_nxt;
    chk_idx_r    <= chk_idx_nxt;
    best_found_r <= best_found_nxt;
    best_sess_r  <= best_sess_nxt;
    best_id_r    <= best_id_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(sslb_pkg::MAX_SERVICES))
    else $error("entry count above table size");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !ram_we)
    else $error("table write while idle");

  a_detach_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SH_RD && !(src_r < count_r)) |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("detach did not remove an entry");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r ##1 out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result loaded outside the done step");

endmodule
`default_nettype wire
